// ----- design/moi_pkg.sv -----
package moi_pkg;
   localparam int CAPACITY = 64;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic signed [31:0] hi;
      logic signed [31:0] lo;
   } span_type;

   // True when a sorts strictly after b (start first, then end).
   function automatic logic key_greater(span_type a, span_type b);
      logic gt;
      if (a.lo != b.lo) begin
         gt = (a.lo > b.lo);
      end else begin
         gt = (a.hi > b.hi);
      end
      return gt;
   endfunction
endpackage

// ----- design/merge_overlapping_intervals_unit.sv -----
// Channel | Direction | Payload
// req     | in        | tdata = interval_start[31:0], interval_end[63:32]; tlast = batch_last
// rsp     | out       | tdata = merged_start[31:0], merged_end[63:32]; tlast = run_last;
//         |           | tuser = dropped_flag
// Loading an item reads the stored entries from the top and shifts up each one that sorts
// after it to make room (insertion into the single-port store); an item that arrives
// while the store is full is dropped and sets the dropped flag for its batch.
// After the last item the sweep reads the entries in order and emits a merged item
// whenever a run closes; rsp stalls hold the sweep. Reset empties the store at once
// through the fill count; stored contents are not cleared.
module merge_overlapping_intervals_unit
   import moi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // interval_start, interval_end
   input  logic        req_tlast,   // batch_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // merged_start, merged_end
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // dropped_flag
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_SRD   = 3'd3;
   localparam logic [2:0] ST_SCMP  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;

   span_type mem [CAPACITY];
   span_type rd_data_ff;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             ovf_ff, ovf_in;
   logic             last_ff, last_in;
   span_type         item_ff, item_in;
   span_type         cur_ff, cur_in;
   logic             rsp_v_ff, rsp_v_in;
   span_type         rsp_d_ff, rsp_d_in;
   logic             rsp_l_ff, rsp_l_in;
   logic             rsp_u_ff, rsp_u_in;

   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   span_type         wr_data;
   logic             out_free;

   assign out_free = !rsp_v_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Single-port style store with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control: insertion sort on load, sweep on last item.
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      last_in = last_ff;
      item_in = item_ff;
      cur_in = cur_ff;
      rsp_v_in = rsp_v_ff && !rsp_tready;
      rsp_d_in = rsp_d_ff;
      rsp_l_in = rsp_l_ff;
      rsp_u_in = rsp_u_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = item_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               item_in = span_type'(req_tdata);
               last_in = req_tlast;
               pos_in = fill_ff;
               if (fill_ff < CNT_W'(CAPACITY)) begin
                  state_in = ST_RD;
               end else begin
                  ovf_in = 1'b1;
                  pos_in = CNT_W'(1);
                  state_in = req_tlast ? ST_SRD : ST_IDLE;
               end
            end
         end
         ST_RD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               wr_addr = '0;
               fill_in = fill_ff + 1'b1;
               pos_in = CNT_W'(1);
               state_in = last_ff ? ST_SRD : ST_IDLE;
            end else begin
               rd_en = 1'b1;
               rd_addr = ADDR_W'(pos_ff - 1'b1);
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            wr_en = 1'b1;
            wr_addr = pos_ff[ADDR_W-1:0];
            if (key_greater(rd_data_ff, item_ff)) begin
               wr_data = rd_data_ff;
               pos_in = pos_ff - 1'b1;
               state_in = ST_RD;
            end else begin
               fill_in = fill_ff + 1'b1;
               pos_in = CNT_W'(1);
               state_in = last_ff ? ST_SRD : ST_IDLE;
            end
         end
         ST_SRD: begin
            // pos 1 first reads entry 0 as the opening run.
            rd_en = 1'b1;
            rd_addr = ADDR_W'(pos_ff - 1'b1);
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (pos_ff == CNT_W'(1)) begin
               cur_in = rd_data_ff;
               pos_in = pos_ff + 1'b1;
               state_in = (fill_ff > CNT_W'(1)) ? ST_SRD : ST_FLUSH;
            end else if (rd_data_ff.lo > cur_ff.hi) begin
               if (out_free) begin
                  rsp_v_in = 1'b1;
                  rsp_d_in = cur_ff;
                  rsp_l_in = 1'b0;
                  rsp_u_in = ovf_ff;
                  cur_in = rd_data_ff;
                  pos_in = pos_ff + 1'b1;
                  state_in = (pos_ff < fill_ff) ? ST_SRD : ST_FLUSH;
               end
            end else begin
               if (rd_data_ff.hi > cur_ff.hi) begin
                  cur_in.hi = rd_data_ff.hi;
               end
               pos_in = pos_ff + 1'b1;
               state_in = (pos_ff < fill_ff) ? ST_SRD : ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               rsp_d_in = cur_ff;
               rsp_l_in = 1'b1;
               rsp_u_in = ovf_ff;
               fill_in = '0;
               ovf_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         ovf_ff <= ovf_in;
         rsp_v_ff <= rsp_v_in;
      end
      pos_ff <= pos_in;
      last_ff <= last_in;
      item_ff <= item_in;
      cur_ff <= cur_in;
      rsp_d_ff <= rsp_d_in;
      rsp_l_ff <= rsp_l_in;
      rsp_u_ff <= rsp_u_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_d_ff;
   assign rsp_tlast = rsp_l_ff;
   assign rsp_tuser = rsp_u_ff;

`ifndef SYNTH
   // The fill count never exceeds the store size.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY)) else $error("fill count above capacity");
   // A last merged item leaves the store empty.
   a_empty_after: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (fill_ff == '0 && !ovf_ff))
      else $error("store not emptied after batch");
   // No input is taken while results are being produced.
   a_no_load_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRD || state_ff == ST_SCMP || state_ff == ST_FLUSH) |-> !req_tready)
      else $error("input accepted during sweep");
`endif
endmodule

// ----- sim/merge_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the interval merger, keeps a shadow copy of the
// sorted store, and checks every merged interval against the prediction.
module merge_checker
   import moi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending_count
);
   typedef struct {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic               last;
      logic               dropped;
   } merged_type;

   logic signed [31:0] shadow_lo [CAPACITY];
   logic signed [31:0] shadow_hi [CAPACITY];
   int         shadow_fill;
   logic       shadow_overflow;
   merged_type merged_queue [$];

   // True when (alo, ahi) sorts strictly after (blo, bhi).
   function automatic logic sorts_after(logic signed [31:0] alo, logic signed [31:0] ahi,
                                        logic signed [31:0] blo, logic signed [31:0] bhi);
      if (alo != blo) return alo > blo;
      return ahi > bhi;
   endfunction

   // Insert one interval, and on the last item of a batch sweep the store.
   task automatic absorb_interval(logic signed [31:0] lo, logic signed [31:0] hi, logic last);
      int pos;
      merged_type cur;
      if (shadow_fill < CAPACITY) begin
         pos = shadow_fill;
         while (pos > 0 && sorts_after(shadow_lo[pos-1], shadow_hi[pos-1], lo, hi)) begin
            shadow_lo[pos] = shadow_lo[pos-1];
            shadow_hi[pos] = shadow_hi[pos-1];
            pos--;
         end
         shadow_lo[pos] = lo;
         shadow_hi[pos] = hi;
         shadow_fill++;
      end else begin
         shadow_overflow = 1'b1;
      end
      if (!last) return;
      cur.lo = shadow_lo[0];
      cur.hi = shadow_hi[0];
      cur.last = 1'b0;
      cur.dropped = shadow_overflow;
      for (int i = 1; i < shadow_fill; i++) begin
         if (shadow_lo[i] > cur.hi) begin
            merged_queue = {merged_queue, cur};
            cur.lo = shadow_lo[i];
            cur.hi = shadow_hi[i];
         end else if (shadow_hi[i] > cur.hi) begin
            cur.hi = shadow_hi[i];
         end
      end
      cur.last = 1'b1;
      merged_queue = {merged_queue, cur};
      shadow_fill = 0;
      shadow_overflow = 1'b0;
   endtask

   always @(posedge clock) begin
      merged_type want;
      if (reset) begin
         shadow_fill = 0;
         shadow_overflow = 1'b0;
         merged_queue.delete();
         fail_count = 0;
      end else begin
         // Compare first so that a result and a new item in one cycle stay ordered.
         if (rsp_tvalid && rsp_tready) begin
            if (merged_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected merged item %h last=%b drop=%b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = merged_queue.pop_front();
               if (rsp_tdata[31:0] !== want.lo || rsp_tdata[63:32] !== want.hi ||
                   rsp_tlast !== want.last || rsp_tuser !== want.dropped) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: want %0d..%0d last=%b drop=%b, ",
                               "got %0d..%0d last=%b drop=%b"},
                              want.lo, want.hi, want.last, want.dropped,
                              $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]),
                              rsp_tlast, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_interval(req_tdata[31:0], req_tdata[63:32], req_tlast);
      end
      pending_count = merged_queue.size();
   end
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import moi_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_off = 1'b0;
   int          idle_cycles = 0;

   always #4 clock = ~clock;

   merge_overlapping_intervals_unit u_dut (.*);
   merge_checker u_checker (.*);

   // Receiver: random stalls, plus one long hold-off when requested.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles with no accepted item on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one interval, with a random gap before it, and wait until accepted.
   // The valid stays high after acceptance so the next item can follow at once;
   // a gap or a drain drops it.
   task automatic send_interval(logic signed [31:0] lo, logic signed [31:0] hi, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {hi, lo};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] random_point(int spread);
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return 32'h7fff_fffc + $urandom_range(3);
         default: return $urandom_range(2 * spread) - spread;
      endcase
   endfunction

   // One batch of n intervals of random shape, mostly clustered so runs merge.
   task automatic send_batch(int n, int spread);
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      for (int i = 0; i < n; i++) begin
         lo = random_point(spread);
         if ($urandom_range(9) == 0) hi = $urandom;
         else hi = lo + $signed($urandom_range(spread / 4 + 1));
         send_interval(lo, hi, i == n - 1);
      end
   endtask

   // Stop offering and wait until every expected result has come.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single interval, extremes, touching, equal keys, reversed.
      send_interval(32'h8000_0000, 32'h7fff_ffff, 1'b1);
      send_interval(32'h7fff_ffff, 32'h8000_0000, 1'b1);
      send_interval(10, 20, 1'b0);
      send_interval(20, 30, 1'b0);
      send_interval(31, 40, 1'b0);
      send_interval(5, 5, 1'b0);
      send_interval(5, 5, 1'b0);
      send_interval(50, 45, 1'b0);
      send_interval(-7, 3, 1'b0);
      send_interval(100, 200, 1'b1);
      send_interval(32'hffff_ffff, 32'h0000_0000, 1'b0);
      send_interval(32'h5555_5555, 32'haaaa_aaaa, 1'b1);
      drain();

      // Overflow: more intervals than the store holds, the last three dropped.
      for (int i = 0; i < CAPACITY + 3; i++)
         send_interval(-3 * i, -3 * i + ((i % 3 == 0) ? 3 : 1), i == CAPACITY + 2);
      drain();

      // Random traffic over the idling phases.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 84 : 23) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 84 : 23) : 0;
         for (int b = 0; b < 5; b++) begin
            send_batch($urandom_range(1, 12), (b % 2) ? 50 : 100000);
         end
      end

      // Long receiver hold-off while batches keep coming, then a full pause.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            send_batch(30, 40);
            send_batch(20, 1000);
         end
      join
      drain();
      send_batch(CAPACITY, 10);
      send_batch(6, 30);

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
design/moi_pkg.sv
design/merge_overlapping_intervals_unit.sv
sim/merge_checker.sv
sim/testbench.sv
